FILE: src/ssvf_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment value formatter package
// Shared types, segment codes and the digit font used by the formatter.
// ----------------------------------------------------------------------------
package ssvf_pkg;

    localparam int CMD_W       = 3;
    localparam int MAG_W       = 25;
    localparam int NUM_DIGITS  = 7;
    localparam int NUM_SEGS    = 8;
    localparam int RECIP_W     = 32;
    localparam int DIV10_SHIFT = 35;
    localparam int QUO_W       = MAG_W + RECIP_W - DIV10_SHIFT;

    localparam logic [RECIP_W-1:0] DIV10_RECIP = 32'hcccc_cccd;

    localparam logic [7:0] SEG_BLANK  = 8'hff;
    localparam logic [7:0] SEG_MINUS  = 8'hbf;
    localparam logic [7:0] SEG_POINT  = 8'h7f;
    localparam logic [7:0] LETTER_C   = 8'hc6;
    localparam logic [7:0] LETTER_L   = 8'hc7;
    localparam logic [7:0] LETTER_U   = 8'hc1;
    localparam logic [7:0] LETTER_B   = 8'h83;
    localparam logic [7:0] LETTER_F   = 8'h8e;
    localparam logic [3:0] DIGIT_NINE = 4'd9;

    typedef enum logic [CMD_W-1:0] {
        MODE_TEMP   = 3'd0,
        MODE_DIST   = 3'd1,
        MODE_VOLT   = 3'd2,
        MODE_BRIGHT = 3'd3,
        MODE_FREQ   = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode cmd;
        logic  neg;
        logic  no_echo;
    } t_info;

    typedef struct packed {
        t_info            info;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;
    typedef logic [NUM_SEGS-1:0][7:0]   t_segs;

    function automatic logic [7:0] digit_font(input logic [3:0] d);
        logic [7:0] f;
        unique case (d)
            4'd0:    f = 8'hc0;
            4'd1:    f = 8'hf9;
            4'd2:    f = 8'ha4;
            4'd3:    f = 8'hb0;
            4'd4:    f = 8'h99;
            4'd5:    f = 8'h92;
            4'd6:    f = 8'h82;
            4'd7:    f = 8'hf8;
            4'd8:    f = 8'h80;
            4'd9:    f = 8'h90;
            default: f = SEG_BLANK;
        endcase
        return f;
    endfunction

endpackage

FILE: src/ssvf_queue.sv
// ----------------------------------------------------------------------------
// Formatter item queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module ssvf_queue #(
    parameter int  DEPTH = 2,
    parameter type T     = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/ssvf_front.sv
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts items, resolves sign and magnitude per mode and queues them.
// ----------------------------------------------------------------------------
module ssvf_front #(
    parameter int DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [ssvf_pkg::CMD_W-1:0]  i_command,
    input  logic signed [ssvf_pkg::MAG_W-1:0] i_value,
    input  logic                        i_no_echo,
    output ssvf_pkg::t_item             o_item,
    output logic                        o_valid,
    input  logic                        i_take
);

    ssvf_pkg::t_item c_item;
    logic            c_neg;
    logic            q_empty;

    always_comb begin
        c_neg = i_value[ssvf_pkg::MAG_W-1]
                && (ssvf_pkg::t_mode'(i_command) == ssvf_pkg::MODE_TEMP);
        c_item.info.cmd     = ssvf_pkg::t_mode'(i_command);
        c_item.info.neg     = c_neg;
        c_item.info.no_echo = i_no_echo;
        c_item.mag          = c_neg ? ssvf_pkg::MAG_W'(-i_value)
                                    : ssvf_pkg::MAG_W'(i_value);
    end

    ssvf_queue #(
        .DEPTH (DEPTH),
        .T     (ssvf_pkg::t_item)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (c_item),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_item),
        .o_empty (q_empty)
    );

    assign o_valid = !q_empty;

endmodule

FILE: src/ssvf_back.sv
// ----------------------------------------------------------------------------
// Formatter back end
// Seven-stage divide-by-ten pipeline followed by the segment encoder.
// ----------------------------------------------------------------------------
module ssvf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ssvf_pkg::t_item i_item,
    input  logic            i_valid,
    output logic            o_take,
    output logic            o_push,
    output ssvf_pkg::t_segs o_segs,
    input  logic            i_full
);

    localparam int ND = ssvf_pkg::NUM_DIGITS;
    localparam int MW = ssvf_pkg::MAG_W;
    localparam int PW = MW + ssvf_pkg::RECIP_W;

    logic [ND-1:0]          r_valid;
    logic [MW-1:0]          r_x [ND-1];
    ssvf_pkg::t_digits      r_digits [ND];
    ssvf_pkg::t_info        r_info [ND];
    logic                   advance;

    assign advance = !(r_valid[ND-1] && i_full);
    assign o_take  = i_valid && advance;
    assign o_push  = r_valid[ND-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (advance) begin
            r_valid <= {r_valid[ND-2:0], o_take};
        end
    end

    for (genvar g = 0; g < ND; g++) begin : g_stage
        logic [MW-1:0]              c_x;
        logic [PW-1:0]              c_prod;
        logic [ssvf_pkg::QUO_W-1:0] c_q;
        logic [3:0]                 c_ten;
        logic [3:0]                 c_digit;
        ssvf_pkg::t_digits          c_digs;
        ssvf_pkg::t_info            c_info;

        if (g == 0) begin : g_first
            assign c_x    = i_item.mag;
            assign c_info = i_item.info;
            always_comb begin
                c_digs    = '0;
                c_digs[g] = c_digit;
            end
        end else begin : g_next
            assign c_x    = r_x[g-1];
            assign c_info = r_info[g-1];
            always_comb begin
                c_digs    = r_digits[g-1];
                c_digs[g] = c_digit;
            end
        end

        assign c_prod  = PW'(c_x) * PW'(ssvf_pkg::DIV10_RECIP);
        assign c_q     = c_prod[PW-1:ssvf_pkg::DIV10_SHIFT];
        assign c_ten   = {c_q[0], 3'b000} + {c_q[2:0], 1'b0};
        assign c_digit = c_x[3:0] - c_ten;

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_digits[g] <= c_digs;
                r_info[g]   <= c_info;
            end
        end

        if (g < ND - 1) begin : g_quo
            always_ff @(posedge i_clk) begin
                if (advance) begin
                    r_x[g] <= MW'(c_q);
                end
            end
        end
    end

    ssvf_pkg::t_digits d;
    ssvf_pkg::t_info   info;
    logic [ND-1:0]     z;
    logic [7:0]        f [ND];
    logic              lead;

    always_comb begin
        d    = r_digits[ND-1];
        info = r_info[ND-1];
        for (int j = 0; j < ND; j++) begin
            f[j] = ssvf_pkg::digit_font(d[j]);
            z[j] = (d[j] == 4'd0);
        end
        o_segs = {ssvf_pkg::NUM_SEGS{ssvf_pkg::SEG_BLANK}};
        lead   = 1'b1;
        unique case (info.cmd)
            ssvf_pkg::MODE_TEMP: begin
                o_segs[0] = ssvf_pkg::LETTER_C;
                o_segs[3] = z[4] ? ssvf_pkg::SEG_BLANK : f[4];
                o_segs[4] = (z[4] && z[3]) ? ssvf_pkg::SEG_BLANK : f[3];
                o_segs[5] = f[2] & ssvf_pkg::SEG_POINT;
                o_segs[6] = f[1];
                o_segs[7] = f[0];
                if (info.neg) begin
                    priority if (z[4] && z[3]) begin
                        o_segs[4] = ssvf_pkg::SEG_MINUS;
                    end else if (z[4]) begin
                        o_segs[3] = ssvf_pkg::SEG_MINUS;
                    end else begin
                        o_segs[2] = ssvf_pkg::SEG_MINUS;
                    end
                end
            end
            ssvf_pkg::MODE_DIST: begin
                o_segs[0] = ssvf_pkg::LETTER_L;
                if (info.no_echo) begin
                    for (int j = 3; j < ssvf_pkg::NUM_SEGS; j++) begin
                        o_segs[j] = ssvf_pkg::digit_font(ssvf_pkg::DIGIT_NINE);
                    end
                end else begin
                    o_segs[3] = z[4] ? ssvf_pkg::SEG_BLANK : f[4];
                    o_segs[4] = (z[4] && z[3]) ? ssvf_pkg::SEG_BLANK : f[3];
                    o_segs[5] = (z[4] && z[3] && z[2]) ? ssvf_pkg::SEG_BLANK : f[2];
                    o_segs[6] = f[1];
                    o_segs[7] = f[0];
                end
                o_segs[6] = o_segs[6] & ssvf_pkg::SEG_POINT;
            end
            ssvf_pkg::MODE_VOLT, ssvf_pkg::MODE_BRIGHT: begin
                o_segs[0] = (info.cmd == ssvf_pkg::MODE_VOLT) ? ssvf_pkg::LETTER_U
                                                              : ssvf_pkg::LETTER_B;
                o_segs[5] = f[2] & ssvf_pkg::SEG_POINT;
                o_segs[6] = f[1];
                o_segs[7] = f[0];
            end
            ssvf_pkg::MODE_FREQ: begin
                o_segs[0] = ssvf_pkg::LETTER_F;
                for (int m = 0; m < ND; m++) begin
                    if (lead && z[ND-1-m]) begin
                        o_segs[1+m] = ssvf_pkg::SEG_BLANK;
                    end else begin
                        lead        = 1'b0;
                        o_segs[1+m] = f[ND-1-m];
                    end
                end
            end
            default: begin
                o_segs = {ssvf_pkg::NUM_SEGS{ssvf_pkg::SEG_BLANK}};
            end
        endcase
    end

endmodule

FILE: src/seven_segment_value_formatter.sv
// ----------------------------------------------------------------------------
// Seven-segment value formatter
// Formats a mode and a reading into eight active-low segment bytes.
// ----------------------------------------------------------------------------
// Each item passes through the input queue, the seven-stage divide-by-ten pipeline and the result queue.
// Throughput: one item per cycle, sustained while results are popped as fast.
// Reset: synchronous; it empties both queues and clears the pipeline valid bits.
module seven_segment_value_formatter #(
    parameter int IN_QUEUE_DEPTH  = 2,
    parameter int OUT_QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic signed [24:0] i_value,
    input  logic        i_no_echo,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_seg0,
    output logic [7:0]  o_seg1,
    output logic [7:0]  o_seg2,
    output logic [7:0]  o_seg3,
    output logic [7:0]  o_seg4,
    output logic [7:0]  o_seg5,
    output logic [7:0]  o_seg6,
    output logic [7:0]  o_seg7
);

    ssvf_pkg::t_item item;
    logic            item_valid;
    logic            item_take;
    logic            res_push;
    logic            res_full;
    ssvf_pkg::t_segs res_segs;
    ssvf_pkg::t_segs out_segs;

    ssvf_front #(
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_command (i_command),
        .i_value   (i_value),
        .i_no_echo (i_no_echo),
        .o_item    (item),
        .o_valid   (item_valid),
        .i_take    (item_take)
    );

    ssvf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_valid (item_valid),
        .o_take  (item_take),
        .o_push  (res_push),
        .o_segs  (res_segs),
        .i_full  (res_full)
    );

    ssvf_queue #(
        .DEPTH (OUT_QUEUE_DEPTH),
        .T     (ssvf_pkg::t_segs)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_segs),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_segs),
        .o_empty (empty)
    );

    assign o_seg0 = out_segs[0];
    assign o_seg1 = out_segs[1];
    assign o_seg2 = out_segs[2];
    assign o_seg3 = out_segs[3];
    assign o_seg4 = out_segs[4];
    assign o_seg5 = out_segs[5];
    assign o_seg6 = out_segs[6];
    assign o_seg7 = out_segs[7];

endmodule

FILE: src/ssvf_checker.sv
// ----------------------------------------------------------------------------
// Formatter port checker
// Watches the top-level ports and checks reset, held results and result shapes.
// ----------------------------------------------------------------------------
module ssvf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_seg0,
    input logic [7:0]  o_seg1,
    input logic [7:0]  o_seg2,
    input logic [7:0]  o_seg3,
    input logic [7:0]  o_seg4,
    input logic [7:0]  o_seg5,
    input logic [7:0]  o_seg6,
    input logic [7:0]  o_seg7
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable({o_seg0, o_seg1, o_seg2, o_seg3,
                                              o_seg4, o_seg5, o_seg6, o_seg7}))
        else $error("waiting result changed");

    a_first_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_seg0 == ssvf_pkg::LETTER_C || o_seg0 == ssvf_pkg::LETTER_L
                || o_seg0 == ssvf_pkg::LETTER_U || o_seg0 == ssvf_pkg::LETTER_B
                || o_seg0 == ssvf_pkg::LETTER_F || o_seg0 == ssvf_pkg::SEG_BLANK)
        else $error("unexpected leftmost digit");

    a_three_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_seg0 == ssvf_pkg::LETTER_U || o_seg0 == ssvf_pkg::LETTER_B)
        |-> o_seg1 == ssvf_pkg::SEG_BLANK && o_seg4 == ssvf_pkg::SEG_BLANK
            && !o_seg5[7] && o_seg7 != ssvf_pkg::SEG_BLANK)
        else $error("three-digit layout broken");

    a_temp_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_seg0 == ssvf_pkg::LETTER_C
        |-> o_seg1 == ssvf_pkg::SEG_BLANK && !o_seg5[7]
            && o_seg6 != ssvf_pkg::SEG_BLANK && o_seg7 != ssvf_pkg::SEG_BLANK)
        else $error("temperature layout broken");

endmodule

bind seven_segment_value_formatter ssvf_checker u_checker (.*);
